[hdl/sium_pkg.sv]
// ----------------------------------------------------------------------------
// sium_pkg
// Shared types and constants for the sorted interval union merger.
// ----------------------------------------------------------------------------
`default_nettype none

package sium_pkg;

    localparam int BOUND_W  = 64;
    localparam int FIELDS_W = 2 * BOUND_W + 2;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - FIELDS_W;

    // one incoming period
    typedef struct packed {
        logic                      final_item;
        logic                      upper_closed;
        logic                      lower_closed;
        logic signed [BOUND_W-1:0] upper_bound;
        logic signed [BOUND_W-1:0] lower_bound;
    } item_t;

    // one emitted merged period
    typedef struct packed {
        logic                      final_result;
        logic                      merged_upper_closed;
        logic                      merged_lower_closed;
        logic signed [BOUND_W-1:0] merged_upper;
        logic signed [BOUND_W-1:0] merged_lower;
    } result_t;

endpackage

`default_nettype wire

[hdl/sium_queue.sv]
// ----------------------------------------------------------------------------
// sium_queue
// Two-entry queue between the input side and the merge engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sium_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire sium_pkg::item_t push_item,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output sium_pkg::item_t     pop_item
);
    import sium_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/sium_merge.sv]
// ----------------------------------------------------------------------------
// sium_merge
// Merge engine: holds the current merged period, widens it with each
// overlapping or adjacent period, and emits finished periods.
// ----------------------------------------------------------------------------
`default_nettype none

module sium_merge (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire sium_pkg::item_t   q_item,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output sium_pkg::result_t      res_data
);
    import sium_pkg::*;

    // held period
    logic signed [BOUND_W-1:0] held_lower_reg;
    logic signed [BOUND_W-1:0] held_lower_next;
    logic signed [BOUND_W-1:0] held_upper_reg;
    logic signed [BOUND_W-1:0] held_upper_next;
    logic                      held_lc_reg;
    logic                      held_lc_next;
    logic                      held_uc_reg;
    logic                      held_uc_next;
    logic                      holding_reg;
    logic                      holding_next;

    // output register and second-result slot
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t pend_reg;
    result_t pend_next;
    logic    pend_valid_reg;
    logic    pend_valid_next;

    logic    out_free;
    logic    ovl;
    logic    adj;
    logic    merge;
    logic    keep_lo;
    logic    keep_hi;
    logic    emit_old;
    result_t old_res;
    result_t new_res;

    assign out_free  = !out_valid_reg || res_ready;
    assign q_pop     = q_valid && out_free && !pend_valid_reg;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    always_comb
    begin
        // equal values: the bounds touch only when both are inclusive
        ovl = ((held_lower_reg < q_item.upper_bound) ||
               (held_lower_reg == q_item.upper_bound && held_lc_reg &&
                q_item.upper_closed)) &&
              ((q_item.lower_bound < held_upper_reg) ||
               (q_item.lower_bound == held_upper_reg && q_item.lower_closed &&
                held_uc_reg));
        adj = (held_upper_reg == q_item.lower_bound &&
               held_uc_reg != q_item.lower_closed) ||
              (q_item.upper_bound == held_lower_reg &&
               q_item.upper_closed != held_lc_reg);
        merge = holding_reg && (ovl || adj);
        keep_lo = (held_lower_reg < q_item.lower_bound) ||
                  (held_lower_reg == q_item.lower_bound &&
                   (held_lc_reg || !q_item.lower_closed));
        keep_hi = (held_upper_reg > q_item.upper_bound) ||
                  (held_upper_reg == q_item.upper_bound &&
                   (held_uc_reg || !q_item.upper_closed));
        emit_old = holding_reg && !merge;

        held_lower_next = held_lower_reg;
        held_upper_next = held_upper_reg;
        held_lc_next    = held_lc_reg;
        held_uc_next    = held_uc_reg;
        holding_next    = holding_reg;

        old_res.merged_lower        = held_lower_reg;
        old_res.merged_upper        = held_upper_reg;
        old_res.merged_lower_closed = held_lc_reg;
        old_res.merged_upper_closed = held_uc_reg;
        old_res.final_result        = 1'b0;

        if (merge)
        begin
            if (!keep_lo)
            begin
                held_lower_next = q_item.lower_bound;
                held_lc_next    = q_item.lower_closed;
            end
            if (!keep_hi)
            begin
                held_upper_next = q_item.upper_bound;
                held_uc_next    = q_item.upper_closed;
            end
        end
        else
        begin
            held_lower_next = q_item.lower_bound;
            held_upper_next = q_item.upper_bound;
            held_lc_next    = q_item.lower_closed;
            held_uc_next    = q_item.upper_closed;
        end

        new_res.merged_lower        = held_lower_next;
        new_res.merged_upper        = held_upper_next;
        new_res.merged_lower_closed = held_lc_next;
        new_res.merged_upper_closed = held_uc_next;
        new_res.final_result        = 1'b1;

        holding_next    = !q_item.final_item;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;

        if (pend_valid_reg)
        begin
            holding_next = holding_reg;
            if (out_free)
            begin
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (q_pop)
        begin
            if (emit_old)
            begin
                out_next       = old_res;
                out_valid_next = 1'b1;
                if (q_item.final_item)
                begin
                    pend_next       = new_res;
                    pend_valid_next = 1'b1;
                end
            end
            else if (q_item.final_item)
            begin
                out_next       = new_res;
                out_valid_next = 1'b1;
            end
        end
        else
        begin
            holding_next = holding_reg;
        end

        if (!q_pop)
        begin
            held_lower_next = held_lower_reg;
            held_upper_next = held_upper_reg;
            held_lc_next    = held_lc_reg;
            held_uc_next    = held_uc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_lower_reg <= '0;
            held_upper_reg <= '0;
            held_lc_reg    <= 1'b0;
            held_uc_reg    <= 1'b0;
            holding_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            held_lower_reg <= held_lower_next;
            held_upper_reg <= held_upper_next;
            held_lc_reg    <= held_lc_next;
            held_uc_reg    <= held_uc_next;
            holding_reg    <= holding_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

endmodule

`default_nettype wire

[hdl/sorted_interval_union_merger.sv]
// A request that completes a result is written into the queue, then popped by
// the merge engine, which loads the result into the output register.
// Throughput: one request per cycle while the output is ready; a final request
// that emits two results holds the merge engine until the second result leaves the second-result slot.
// Reset: rst_n clears the held period, the queue and the output valids.
// ----------------------------------------------------------------------------
// sorted_interval_union_merger
// Merges a sorted stream of periods into a stream of disjoint unions.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_interval_union_merger (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // lower_bound, upper_bound, lower_closed, upper_closed, zero pad
    input  wire logic [sium_pkg::TDATA_W-1:0] s_tdata,
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // merged_lower, merged_upper, merged_lower_closed, merged_upper_closed, zero pad
    output logic [sium_pkg::TDATA_W-1:0]      m_tdata,
    output logic                              m_tlast
);
    import sium_pkg::*;

    item_t   in_item;
    item_t   q_item;
    logic    q_valid;
    logic    q_pop;
    result_t res;

    assign in_item.lower_bound  = s_tdata[BOUND_W-1:0];
    assign in_item.upper_bound  = s_tdata[2*BOUND_W-1:BOUND_W];
    assign in_item.lower_closed = s_tdata[2*BOUND_W];
    assign in_item.upper_closed = s_tdata[2*BOUND_W+1];
    assign in_item.final_item   = s_tlast;

    sium_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (in_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_item   (q_item)
    );

    sium_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res)
    );

    assign m_tdata = {{PAD_W{1'b0}}, res.merged_upper_closed, res.merged_lower_closed,
                      res.merged_upper, res.merged_lower};
    assign m_tlast = res.final_result;

endmodule

`default_nettype wire

[sim/period_merge_checker.sv]
// ----------------------------------------------------------------------------
// period_merge_checker
// Watches both stream ports of the interval union merger. Every accepted
// request goes through a local model of the held-period merge, and every
// emitted merged period is compared field by field with the oldest one
// that the model predicted.
// ----------------------------------------------------------------------------
module period_merge_checker
    import sium_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               m_tlast,
    output int                 mismatch_total,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // period currently being grown
    logic signed [BOUND_W-1:0] span_lo;
    logic signed [BOUND_W-1:0] span_hi;
    logic                      span_lo_inc;
    logic                      span_hi_inc;
    logic                      span_open;

    result_t merged_due[$];

    // order of two bounds; on equal values an exclusive lower bound sits just
    // above the value and an exclusive upper bound just below it
    function automatic int rank_bounds(logic signed [BOUND_W-1:0] v1, logic inc1, logic is_lo1,
                                       logic signed [BOUND_W-1:0] v2, logic inc2, logic is_lo2);
        if (v1 < v2)
            return -1;
        if (v1 > v2)
            return 1;
        if (!inc1 && !inc2)
        begin
            if (is_lo1 == is_lo2)
                return 0;
            return is_lo1 ? 1 : -1;
        end
        if (!inc1)
            return is_lo1 ? 1 : -1;
        if (!inc2)
            return is_lo2 ? -1 : 1;
        return 0;
    endfunction

    function automatic void queue_span(logic last_one);
        result_t r;
        r.merged_lower        = span_lo;
        r.merged_upper        = span_hi;
        r.merged_lower_closed = span_lo_inc;
        r.merged_upper_closed = span_hi_inc;
        r.final_result        = last_one;
        merged_due.push_back(r);
    endfunction

    function automatic void absorb_period(item_t p);
        logic overlap;
        logic touch;
        logic keep_lo;
        logic keep_hi;
        if (span_open)
        begin
            overlap = rank_bounds(span_lo, span_lo_inc, 1'b1,
                                  p.upper_bound, p.upper_closed, 1'b0) <= 0 &&
                      rank_bounds(p.lower_bound, p.lower_closed, 1'b1,
                                  span_hi, span_hi_inc, 1'b0) <= 0;
            // touching: same value, exactly one side inclusive
            touch = (span_hi == p.lower_bound && span_hi_inc != p.lower_closed) ||
                    (p.upper_bound == span_lo && p.upper_closed != span_lo_inc);
            if (overlap || touch)
            begin
                keep_lo = span_lo < p.lower_bound ||
                          (span_lo == p.lower_bound && (span_lo_inc || !p.lower_closed));
                keep_hi = span_hi > p.upper_bound ||
                          (span_hi == p.upper_bound && (span_hi_inc || !p.upper_closed));
                if (!keep_lo)
                begin
                    span_lo     = p.lower_bound;
                    span_lo_inc = p.lower_closed;
                end
                if (!keep_hi)
                begin
                    span_hi     = p.upper_bound;
                    span_hi_inc = p.upper_closed;
                end
            end
            else
            begin
                queue_span(1'b0);
                span_lo     = p.lower_bound;
                span_hi     = p.upper_bound;
                span_lo_inc = p.lower_closed;
                span_hi_inc = p.upper_closed;
            end
        end
        else
        begin
            span_lo     = p.lower_bound;
            span_hi     = p.upper_bound;
            span_lo_inc = p.lower_closed;
            span_hi_inc = p.upper_closed;
            span_open   = 1'b1;
        end
        if (p.final_item)
        begin
            queue_span(1'b1);
            span_open = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, logic [BOUND_W-1:0] want,
                                        logic [BOUND_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge clk)
    begin
        item_t   req;
        result_t want;
        if (!rst_n)
        begin
            span_lo     = '0;
            span_hi     = '0;
            span_lo_inc = 1'b0;
            span_hi_inc = 1'b0;
            span_open   = 1'b0;
            merged_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (merged_due.size() == 0)
                begin
                    $error("unexpected merged period: lower %0h upper %0h last %0b",
                           m_tdata[BOUND_W-1:0], m_tdata[2*BOUND_W-1:BOUND_W], m_tlast);
                    mismatch_total++;
                end
                else
                begin
                    want = merged_due.pop_front();
                    check_field("merged_lower", want.merged_lower, m_tdata[BOUND_W-1:0]);
                    check_field("merged_upper", want.merged_upper,
                                m_tdata[2*BOUND_W-1:BOUND_W]);
                    check_field("merged_lower_closed", BOUND_W'(want.merged_lower_closed),
                                BOUND_W'(m_tdata[2*BOUND_W]));
                    check_field("merged_upper_closed", BOUND_W'(want.merged_upper_closed),
                                BOUND_W'(m_tdata[2*BOUND_W+1]));
                    check_field("final_result", BOUND_W'(want.final_result),
                                BOUND_W'(m_tlast));
                    check_field("tdata pad", '0, BOUND_W'(m_tdata[TDATA_W-1:FIELDS_W]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                req.lower_bound  = s_tdata[BOUND_W-1:0];
                req.upper_bound  = s_tdata[2*BOUND_W-1:BOUND_W];
                req.lower_closed = s_tdata[2*BOUND_W];
                req.upper_closed = s_tdata[2*BOUND_W+1];
                req.final_item   = s_tlast;
                absorb_period(req);
            end
        end
        pending = merged_due.size();
    end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives sorted period requests into the interval union merger: a directed
// set of boundary and touching cases, then random runs of nearby periods
// with some noise, under random idle and backpressure. The checker module
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sium_pkg::*;

    localparam int RUN_LIMIT       = 100000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int ITEM_TARGET     = 1250;
    localparam int CALM_ITEMS_FROM = 450;
    localparam int CALM_ITEMS_TO   = 850;
    localparam int CALM_CYC_FROM   = 600;
    localparam int CALM_CYC_TO     = 1100;

    localparam logic signed [BOUND_W-1:0] T_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [BOUND_W-1:0] T_MIN = 64'sh8000_0000_0000_0000;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    int                 mismatch_total;
    int                 pending;
    int                 cycle_count = 0;
    int                 item_count  = 0;

    sorted_interval_union_merger u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    period_merge_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_total (mismatch_total),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // sink backpressure, with a calm window of full throughput
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (cycle_count >= CALM_CYC_FROM && cycle_count < CALM_CYC_TO) ||
                        ($urandom_range(0, 99) >= 9);
    end

    function automatic item_t period(logic signed [BOUND_W-1:0] lo, logic signed [BOUND_W-1:0] hi,
                                     logic lc, logic hc, logic fin);
        item_t p;
        p.lower_bound  = lo;
        p.upper_bound  = hi;
        p.lower_closed = lc;
        p.upper_closed = hc;
        p.final_item   = fin;
        return p;
    endfunction

    task automatic send_period(item_t p);
        @(negedge clk);
        if (item_count < CALM_ITEMS_FROM || item_count >= CALM_ITEMS_TO)
            while ($urandom_range(0, 99) < 9)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({p.upper_closed, p.lower_closed, p.upper_bound, p.lower_bound});
        s_tlast  <= p.final_item;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        item_count++;
    endtask

    // runs of nearby, mostly sorted periods so that overlap and touching are
    // common; a tenth of the runs are fully random, a few lack the last mark
    task automatic random_runs(int target);
        logic signed [BOUND_W-1:0] cursor;
        logic signed [BOUND_W-1:0] lo;
        logic signed [BOUND_W-1:0] hi;
        int                        run_len;
        int                        pick;
        bit                        noisy;
        bit                        fin;
        while (item_count < target)
        begin
            run_len = $urandom_range(1, 12);
            pick    = $urandom_range(0, 99);
            if (pick < 30)
                cursor = {$urandom, $urandom};
            else if (pick < 80)
                cursor = 64'($urandom_range(0, 80)) - 40;
            else if (pick < 90)
                cursor = T_MAX - 64;
            else
                cursor = T_MIN;
            noisy = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < run_len; k++)
            begin
                if (noisy)
                begin
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
                else
                begin
                    if ($urandom_range(0, 7) == 0)
                        cursor = cursor + $urandom_range(0, 5000);
                    else
                        cursor = cursor + $urandom_range(0, 3);
                    lo = cursor;
                    hi = lo + $urandom_range(0, 6);
                    if ($urandom_range(0, 19) == 0)
                        hi = lo - 1;
                end
                fin = (k == run_len - 1) && ($urandom_range(0, 9) != 0);
                send_period(period(lo, hi, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), fin));
            end
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // nothing held and last: emitted at once
        send_period(period(T_MIN, T_MAX, 1'b1, 1'b1, 1'b1));
        send_period(period(5, 5, 1'b0, 1'b0, 1'b1));
        // chain of touching periods, then a gap at a double exclusive bound
        send_period(period(T_MIN, -5, 1'b1, 1'b0, 1'b0));
        send_period(period(-5, 0, 1'b1, 1'b1, 1'b0));
        send_period(period(0, 10, 1'b0, 1'b1, 1'b0));
        send_period(period(10, 20, 1'b0, 1'b0, 1'b0));
        send_period(period(20, 30, 1'b0, 1'b0, 1'b0));
        send_period(period(25, 28, 1'b1, 1'b1, 1'b0));
        send_period(period(30, 40, 1'b1, 1'b1, 1'b0));
        send_period(period(40, 40, 1'b1, 1'b1, 1'b0));
        send_period(period(40, 50, 1'b0, 1'b0, 1'b0));
        // last request not merged: two results
        send_period(period(100, T_MAX, 1'b1, 1'b0, 1'b1));
        // equal lower bounds, inclusive wins; last request merged
        send_period(period(0, 10, 1'b0, 1'b0, 1'b0));
        send_period(period(0, 3, 1'b1, 1'b1, 1'b0));
        send_period(period(10, T_MAX, 1'b1, 1'b1, 1'b1));
        // start above end, then out of order
        send_period(period(50, 10, 1'b1, 1'b1, 1'b0));
        send_period(period(-100, -90, 1'b1, 1'b1, 1'b0));
        send_period(period(-95, 60, 1'b0, 1'b0, 1'b0));
        send_period(period(T_MIN, T_MIN, 1'b0, 1'b0, 1'b1));
        send_period(period(T_MAX, T_MAX, 1'b1, 1'b1, 1'b1));

        random_runs(ITEM_TARGET);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_total == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
